// ===== rtl/gtd_pkg.sv =====
// ----------------------------------------------------------------------------
// gtd_pkg
// Shared constants, register indexes and the CORDIC arctangent table of the
// Goertzel tone detector.
// ----------------------------------------------------------------------------
package gtd_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int STATE_BITS_DEF   = 48;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int COEFF_BITS   = 16;
  localparam int MAG_BITS     = 48;
  localparam int PHASE_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int ACC_BITS     = 96;
  localparam int ANGLE_BITS   = 34;
  localparam int ATAN_IDX_BITS = 5;

  localparam int FRAC_COEFF = 14;
  localparam int FRAC_TRIG  = 15;
  localparam int FRAC_GAIN  = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COS   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIN   = 2'd2;

  localparam logic signed [COEFF_BITS-1:0] COEFF_RESET = 16'sd0;
  localparam logic signed [COEFF_BITS-1:0] COS_RESET   = 16'sd32767;
  localparam logic signed [COEFF_BITS-1:0] SIN_RESET   = 16'sd0;

  localparam logic [31:0]           GAIN_INV  = 32'd2608131496;
  localparam logic [MAG_BITS-1:0]   MAG_LIMIT = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [ANGLE_BITS-1:0] ANGLE_PI   = 34'sd2147483648;
  localparam logic signed [ANGLE_BITS-1:0] PHASE_HALF = 34'sd32768;

  // arctangent of 2^-idx in units of pi / 2^31
  function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_BITS-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/gtd_if.sv =====
// ----------------------------------------------------------------------------
// gtd_if
// Valid/ready channels of the tone detector: configuration writes, samples
// and results.
// ----------------------------------------------------------------------------
interface gtd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gtd_pkg::CFG_IDX_BITS-1:0]  index;
  logic [gtd_pkg::COEFF_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface gtd_sample_if #(
  parameter int SAMPLE_BITS = gtd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface gtd_result_if;
  logic                            valid;
  logic                            ready;
  logic [gtd_pkg::MAG_BITS-1:0]    magnitude;
  logic [gtd_pkg::PHASE_BITS-1:0]  phase;

  modport source (output valid, output magnitude, output phase, input ready);
  modport sink   (input valid, input magnitude, input phase, output ready);
endinterface

// ===== rtl/gtd_cordic_rot.sv =====
// ----------------------------------------------------------------------------
// gtd_cordic_rot
// One vectoring micro-rotation: drives y toward zero and accumulates the
// angle taken from the arctangent table.
// ----------------------------------------------------------------------------
module gtd_cordic_rot #(
  parameter int CW = 50,
  parameter int IW = 4
) (
  input  logic signed [CW-1:0]                  x_in,
  input  logic signed [CW-1:0]                  y_in,
  input  logic signed [gtd_pkg::ANGLE_BITS-1:0] z_in,
  input  logic        [IW-1:0]                  iter,
  output logic signed [CW-1:0]                  x_out,
  output logic signed [CW-1:0]                  y_out,
  output logic signed [gtd_pkg::ANGLE_BITS-1:0] z_out
);

  logic signed [CW-1:0]                  dx;
  logic signed [CW-1:0]                  dy;
  logic signed [gtd_pkg::ANGLE_BITS-1:0] ang;

  assign dx  = y_in >>> iter;
  assign dy  = x_in >>> iter;
  assign ang = signed'(gtd_pkg::ANGLE_BITS'(
                 gtd_pkg::atan_entry(gtd_pkg::ATAN_IDX_BITS'(iter))));

  always_comb begin
    if (y_in > 0) begin
      x_out = x_in + dx;
      y_out = y_in - dy;
      z_out = z_in + ang;
    end else begin
      x_out = x_in - dx;
      y_out = y_in + dy;
      z_out = z_in - ang;
    end
  end

endmodule

// ===== rtl/goertzel_tone_detector.sv =====
// ----------------------------------------------------------------------------
// goertzel_tone_detector
// Goertzel recurrence on saturating accumulators; on the last sample of a
// block, magnitude and phase of the bin come from a vectoring CORDIC.
// Sequence: a sample without the last flag runs S_PREP, S_MUL_LO, S_MUL_HI,
//   S_ROUND, S_ADD and S_SUB before the next one is taken (one 32x32
//   multiplier, two passes). A last sample adds the real, imaginary and
//   magnitude products and the CORDIC (four products, one CORDIC rotation per
//   cycle; a zero vector skips the rotations) before the result valid rises,
//   later if the sink still holds the result; samples.ready rises with it.
// Reset: synchronous, clears the accumulators, the result valid and the
//   configuration registers to their defaults.
// ----------------------------------------------------------------------------
module goertzel_tone_detector #(
  parameter int SAMPLE_BITS  = gtd_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_BITS   = gtd_pkg::STATE_BITS_DEF,
  parameter int CORDIC_STEPS = gtd_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  gtd_cfg_if.sink      cfg,
  gtd_sample_if.sink   samples,
  gtd_result_if.source results
);

  localparam int PRE = (STATE_BITS > 60) ? STATE_BITS - 60 : 0;
  localparam int VW  = STATE_BITS - PRE;
  localparam int CW  = VW + 2;
  localparam int IW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int AW  = gtd_pkg::ACC_BITS;
  localparam int ZW  = gtd_pkg::ANGLE_BITS;
  localparam int CB  = gtd_pkg::COEFF_BITS;

  localparam logic signed [63:0] ST_MAX = (64'sd1 <<< (STATE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] ST_MIN = -ST_MAX - 64'sd1;
  localparam logic [AW-1:0] POS_LIM = (AW'(1) << (STATE_BITS - 1)) - AW'(1);
  localparam logic [AW-1:0] NEG_LIM = AW'(1) << (STATE_BITS - 1);
  localparam logic [AW-1:0] MAG_CAP = AW'(gtd_pkg::MAG_LIMIT) >> PRE;
  localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PREP   = 9'b000000010,
    S_MUL_LO = 9'b000000100,
    S_MUL_HI = 9'b000001000,
    S_ROUND  = 9'b000010000,
    S_ADD    = 9'b000100000,
    S_SUB    = 9'b001000000,
    S_CINIT  = 9'b010000000,
    S_CROT   = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_REAL,
    OP_IMAG,
    OP_MAG
  } op_t;

  state_t state;
  op_t    op;

  logic signed [CB-1:0]         coeff;
  logic signed [CB-1:0]         cos_w;
  logic signed [CB-1:0]         sin_w;
  logic signed [STATE_BITS-1:0] d1;
  logic signed [STATE_BITS-1:0] d2;
  logic signed [STATE_BITS-1:0] xs;
  logic                         last_r;
  logic signed [STATE_BITS-1:0] sum_r;
  logic signed [STATE_BITS-1:0] prod_r;
  logic signed [STATE_BITS-1:0] re_r;
  logic signed [STATE_BITS-1:0] im_r;
  logic [31:0]                  a_lo;
  logic [31:0]                  a_hi;
  logic [31:0]                  mul_b;
  logic                         neg;
  logic [AW-1:0]                acc;
  logic signed [CW-1:0]         cx;
  logic signed [CW-1:0]         cy;
  logic signed [ZW-1:0]         cz;
  logic [IW-1:0]                iter;
  logic                         out_valid;
  logic [gtd_pkg::MAG_BITS-1:0]   magnitude;
  logic [gtd_pkg::PHASE_BITS-1:0] phase;

  function automatic logic signed [STATE_BITS-1:0] sat_addsub(
    input logic signed [STATE_BITS-1:0] a,
    input logic signed [STATE_BITS-1:0] b,
    input logic                         sub
  );
    logic signed [STATE_BITS:0] r;
    logic signed [STATE_BITS-1:0] v;
    if (sub) begin
      r = (STATE_BITS + 1)'(a) - (STATE_BITS + 1)'(b);
    end else begin
      r = (STATE_BITS + 1)'(a) + (STATE_BITS + 1)'(b);
    end
    if (r[STATE_BITS] != r[STATE_BITS-1]) begin
      v = r[STATE_BITS] ? ST_MIN[STATE_BITS-1:0] : ST_MAX[STATE_BITS-1:0];
    end else begin
      v = r[STATE_BITS-1:0];
    end
    return v;
  endfunction

  // sample clamp into the accumulator range
  logic signed [63:0]           smp_ext;
  logic signed [STATE_BITS-1:0] smp_clamped;

  assign smp_ext = 64'(signed'(samples.sample[SAMPLE_BITS-1:0]));

  always_comb begin
    if (smp_ext > ST_MAX) begin
      smp_clamped = ST_MAX[STATE_BITS-1:0];
    end else if (smp_ext < ST_MIN) begin
      smp_clamped = ST_MIN[STATE_BITS-1:0];
    end else begin
      smp_clamped = smp_ext[STATE_BITS-1:0];
    end
  end

  // operand preparation: magnitudes and product sign
  logic signed [STATE_BITS-1:0] pa;
  logic signed [CB-1:0]         pc;
  logic [STATE_BITS-1:0]        pa_abs;
  logic [CB-1:0]                pc_abs;
  logic [CW-2:0]                ux;
  logic [63:0]                  prep_a;
  logic [31:0]                  prep_b;
  logic                         prep_neg;

  always_comb begin
    case (op)
      OP_SAMPLE: begin
        pa = d1;
        pc = coeff;
      end
      OP_REAL: begin
        pa = d2;
        pc = cos_w;
      end
      OP_IMAG: begin
        pa = d2;
        pc = sin_w;
      end
      default: begin
        pa = d1;
        pc = coeff;
      end
    endcase
    pa_abs = pa[STATE_BITS-1] ? -pa : pa;
    pc_abs = pc[CB-1] ? -pc : pc;
    ux     = (cx > 0) ? cx[CW-2:0] : '0;
    if (op == OP_MAG) begin
      prep_a   = 64'(ux);
      prep_b   = gtd_pkg::GAIN_INV;
      prep_neg = 1'b0;
    end else begin
      prep_a   = 64'(pa_abs);
      prep_b   = 32'(pc_abs);
      prep_neg = pa[STATE_BITS-1] ^ pc[CB-1];
    end
  end

  // shared multiplier
  logic [31:0] mul_x;
  logic [63:0] mul_p;

  assign mul_x = (state == S_MUL_LO) ? a_lo : a_hi;
  assign mul_p = 64'(mul_x) * 64'(mul_b);

  // rounding, saturation and magnitude limit
  logic [AW-1:0]                rnd;
  logic [AW-1:0]                q;
  logic [AW-1:0]                q_sh;
  logic signed [STATE_BITS-1:0] prod_v;
  logic [gtd_pkg::MAG_BITS-1:0] mag_v;
  logic signed [ZW-1:0]         pz;

  always_comb begin
    case (op)
      OP_SAMPLE: begin
        rnd = acc + (AW'(1) << (gtd_pkg::FRAC_COEFF - 1));
        q   = rnd >> gtd_pkg::FRAC_COEFF;
      end
      OP_MAG: begin
        rnd = acc + (AW'(1) << (gtd_pkg::FRAC_GAIN - 1));
        q   = rnd >> gtd_pkg::FRAC_GAIN;
      end
      default: begin
        rnd = acc + (AW'(1) << (gtd_pkg::FRAC_TRIG - 1));
        q   = rnd >> gtd_pkg::FRAC_TRIG;
      end
    endcase
    if (!neg) begin
      prod_v = (q > POS_LIM) ? ST_MAX[STATE_BITS-1:0] : q[STATE_BITS-1:0];
    end else begin
      prod_v = (q > NEG_LIM) ? ST_MIN[STATE_BITS-1:0] : -q[STATE_BITS-1:0];
    end
    q_sh  = q << PRE;
    mag_v = (q > MAG_CAP) ? gtd_pkg::MAG_LIMIT : q_sh[gtd_pkg::MAG_BITS-1:0];
    pz    = cz + gtd_pkg::PHASE_HALF;
  end

  // shared saturating adder
  logic signed [STATE_BITS-1:0] add_a;
  logic signed [STATE_BITS-1:0] add_b;
  logic                         add_sub;
  logic signed [STATE_BITS-1:0] add_res;

  always_comb begin
    if (state == S_ADD) begin
      add_a   = xs;
      add_b   = prod_r;
      add_sub = 1'b0;
    end else if (op == OP_SAMPLE) begin
      add_a   = sum_r;
      add_b   = d2;
      add_sub = 1'b1;
    end else begin
      add_a   = d1;
      add_b   = prod_r;
      add_sub = 1'b1;
    end
    add_res = sat_addsub(add_a, add_b, add_sub);
  end

  // CORDIC start vector
  logic signed [STATE_BITS-1:0] re_sh;
  logic signed [STATE_BITS-1:0] im_sh;
  logic signed [CW-1:0]         x0;
  logic signed [CW-1:0]         y0;

  assign re_sh = re_r >>> PRE;
  assign im_sh = im_r >>> PRE;
  assign x0    = CW'(signed'(re_sh[VW-1:0]));
  assign y0    = CW'(signed'(im_sh[VW-1:0]));

  logic signed [CW-1:0] rx;
  logic signed [CW-1:0] ry;
  logic signed [ZW-1:0] rz;

  gtd_cordic_rot #(
    .CW (CW),
    .IW (IW)
  ) u_rot (
    .x_in  (cx),
    .y_in  (cy),
    .z_in  (cz),
    .iter  (iter),
    .x_out (rx),
    .y_out (ry),
    .z_out (rz)
  );

  assign cfg.ready         = 1'b1;
  assign samples.ready     = (state == S_IDLE);
  assign results.valid     = out_valid;
  assign results.magnitude = magnitude;
  assign results.phase     = phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_SAMPLE;
      out_valid <= 1'b0;
      d1        <= '0;
      d2        <= '0;
      coeff     <= gtd_pkg::COEFF_RESET;
      cos_w     <= gtd_pkg::COS_RESET;
      sin_w     <= gtd_pkg::SIN_RESET;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          gtd_pkg::CFG_COEFF: coeff <= signed'(cfg.data);
          gtd_pkg::CFG_COS:   cos_w <= signed'(cfg.data);
          gtd_pkg::CFG_SIN:   sin_w <= signed'(cfg.data);
          default: ;
        endcase
      end
      if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            xs     <= smp_clamped;
            last_r <= samples.last_sample;
            op     <= OP_SAMPLE;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          a_lo  <= prep_a[31:0];
          a_hi  <= prep_a[63:32];
          mul_b <= prep_b;
          neg   <= prep_neg;
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          acc   <= AW'(mul_p);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc   <= acc + (AW'(mul_p) << 32);
          state <= S_ROUND;
        end
        S_ROUND: begin
          case (op)
            OP_SAMPLE: begin
              prod_r <= prod_v;
              state  <= S_ADD;
            end
            OP_REAL: begin
              prod_r <= prod_v;
              state  <= S_SUB;
            end
            OP_IMAG: begin
              im_r  <= prod_v;
              d1    <= '0;
              d2    <= '0;
              state <= S_CINIT;
            end
            default: begin
              if (!out_valid || results.ready) begin
                magnitude <= mag_v;
                phase     <= pz[31:16];
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
            end
          endcase
        end
        S_ADD: begin
          sum_r <= add_res;
          state <= S_SUB;
        end
        S_SUB: begin
          if (op == OP_SAMPLE) begin
            d2 <= d1;
            d1 <= add_res;
            if (last_r) begin
              op    <= OP_REAL;
              state <= S_PREP;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            re_r  <= add_res;
            op    <= OP_IMAG;
            state <= S_PREP;
          end
        end
        S_CINIT: begin
          if (re_r == '0 && im_r == '0) begin
            cx    <= '0;
            cy    <= '0;
            cz    <= '0;
            op    <= OP_MAG;
            state <= S_PREP;
          end else begin
            if (x0 < 0) begin
              cx <= -x0;
              cy <= -y0;
              cz <= (y0 >= 0) ? gtd_pkg::ANGLE_PI : -gtd_pkg::ANGLE_PI;
            end else begin
              cx <= x0;
              cy <= y0;
              cz <= '0;
            end
            iter  <= '0;
            state <= S_CROT;
          end
        end
        S_CROT: begin
          cx   <= rx;
          cy   <= ry;
          cz   <= rz;
          iter <= IW'(iter + 1'b1);
          if (iter == LAST_ITER) begin
            op    <= OP_MAG;
            state <= S_PREP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && op == OP_MAG) |-> (d1 == '0 && d2 == '0))
    else $error("accumulators not cleared before result");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && op == OP_MAG && out_valid && !results.ready)
    |=> (state == S_ROUND && out_valid && $stable(magnitude) && $stable(phase)))
    else $error("pending result overwritten");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CROT) |-> (iter <= LAST_ITER))
    else $error("rotation count out of range");
`endif

endmodule
